### rtl/igbc_pkg.sv
package igbc_pkg;

   localparam int MaxSamples = 4096;
   localparam int CountW = $clog2(MaxSamples + 1);
   localparam int SumW = 29;
   localparam int BiasW = 25;
   localparam int CorrW = 25;
   localparam int DivW = SumW + 8;
   localparam int GsqW = 2 * CorrW + 2;
   localparam int RootW = GsqW / 2;
   localparam int AsqW = 34;
   localparam int AccelRootW = AsqW / 2;

   localparam logic [1:0] CMD_ACCUM = 2'd0;
   localparam logic [1:0] CMD_FINISH = 2'd1;
   localparam logic [1:0] CMD_CONVERT = 2'd2;

   localparam logic [2:0] ST_CONVERTED = 3'd0;
   localparam logic [2:0] ST_ACCUMULATED = 3'd1;
   localparam logic [2:0] ST_BIAS_UPDATED = 3'd2;
   localparam logic [2:0] ST_NO_SAMPLES = 3'd3;
   localparam logic [2:0] ST_DROPPED = 3'd4;

   typedef struct packed {
      logic load;
      logic accumulate;
      logic div_start;
      logic div_step;
      logic div_store;
      logic finish_clear;
      logic sq_start;
      logic sq_step;
      logic sqrt_step;
   } cmd_type;

   typedef struct packed {
      logic [1:0] command;
      logic count_full;
      logic count_zero;
   } stat_type;

endpackage

### rtl/igbc_datapath.sv
module igbc_datapath (
   input  logic clock,
   input  logic reset,
   input  igbc_pkg::cmd_type cmd,
   output igbc_pkg::stat_type stat,
   input  logic [1:0] req_command,
   input  logic signed [15:0] req_accel_raw_x,
   input  logic signed [15:0] req_accel_raw_y,
   input  logic signed [15:0] req_accel_raw_z,
   input  logic signed [15:0] req_gyro_raw_x,
   input  logic signed [15:0] req_gyro_raw_y,
   input  logic signed [15:0] req_gyro_raw_z,
   output logic signed [24:0] gyro_corr_x,
   output logic signed [24:0] gyro_corr_y,
   output logic signed [24:0] gyro_corr_z,
   output logic [24:0] gyro_mag,
   output logic [15:0] accel_mag,
   output logic signed [23:0] bias_x,
   output logic signed [23:0] bias_y,
   output logic signed [23:0] bias_z
);
   import igbc_pkg::*;

   logic [1:0] command_ff;
   logic signed [15:0] acc_ff [3];
   logic signed [15:0] gyr_ff [3];
   logic signed [SumW-1:0] sum_ff [3];
   logic [CountW-1:0] count_ff;
   logic signed [BiasW-1:0] bias_ff [3];
   logic signed [CorrW-1:0] corr_ff [3];
   logic [DivW-1:0] rem_ff [3];
   logic [DivW-1:0] quo_ff [3];
   logic neg_ff [3];
   logic [GsqW-1:0] gsq_ff;
   logic [AsqW-1:0] asq_ff;
   logic [1:0] sq_idx_ff;
   logic [GsqW-1:0] grem_ff, groot_ff, gbit_ff;
   logic [AsqW-1:0] arem_ff, aroot_ff, abit_ff;
   logic signed [31:0] sq_c;
   logic signed [63:0] sq_g;
   logic signed [31:0] sq_a;
   logic [DivW-1:0] rem_sh [3];
   logic [GsqW-1:0] gtry;
   logic [AsqW-1:0] atry;
   logic unused;

   assign stat.command = command_ff;
   assign stat.count_full = count_ff >= CountW'(MaxSamples);
   assign stat.count_zero = count_ff == '0;

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         rem_sh[i] = {rem_ff[i][DivW-2:0], quo_ff[i][DivW-1]};
      end
      sq_c = (sq_idx_ff == 2'd0) ? 32'(corr_ff[0]) :
             (sq_idx_ff == 2'd1) ? 32'(corr_ff[1]) : 32'(corr_ff[2]);
      sq_g = sq_c * sq_c;
      sq_a = (sq_idx_ff == 2'd0) ? 32'(acc_ff[0]) :
             (sq_idx_ff == 2'd1) ? 32'(acc_ff[1]) : 32'(acc_ff[2]);
      gtry = groot_ff + gbit_ff;
      atry = aroot_ff + abit_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         for (int i = 0; i < 3; i++) begin
            sum_ff[i] <= '0;
            bias_ff[i] <= '0;
         end
      end else begin
         if (cmd.accumulate) begin
            sum_ff[0] <= sum_ff[0] + SumW'(gyr_ff[0]);
            sum_ff[1] <= sum_ff[1] + SumW'(gyr_ff[1]);
            sum_ff[2] <= sum_ff[2] + SumW'(gyr_ff[2]);
            count_ff <= count_ff + 1'b1;
         end
         if (cmd.div_store) begin
            for (int i = 0; i < 3; i++)
               bias_ff[i] <= neg_ff[i] ? -BiasW'(quo_ff[i]) : BiasW'(quo_ff[i]);
         end
         if (cmd.finish_clear) begin
            count_ff <= '0;
            for (int i = 0; i < 3; i++) sum_ff[i] <= '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         command_ff <= req_command;
         acc_ff[0] <= req_accel_raw_x;
         acc_ff[1] <= req_accel_raw_y;
         acc_ff[2] <= req_accel_raw_z;
         gyr_ff[0] <= req_gyro_raw_x;
         gyr_ff[1] <= req_gyro_raw_y;
         gyr_ff[2] <= req_gyro_raw_z;
      end
      if (cmd.div_start) begin
         for (int i = 0; i < 3; i++) begin
            neg_ff[i] <= sum_ff[i][SumW-1];
            quo_ff[i] <= {sum_ff[i][SumW-1] ? -sum_ff[i] : sum_ff[i], 8'd0};
            rem_ff[i] <= '0;
         end
      end else if (cmd.div_step) begin
         for (int i = 0; i < 3; i++) begin
            if (rem_sh[i] >= DivW'(count_ff)) begin
               rem_ff[i] <= rem_sh[i] - DivW'(count_ff);
               quo_ff[i] <= {quo_ff[i][DivW-2:0], 1'b1};
            end else begin
               rem_ff[i] <= rem_sh[i];
               quo_ff[i] <= {quo_ff[i][DivW-2:0], 1'b0};
            end
         end
      end
      if (cmd.sq_start) begin
         for (int i = 0; i < 3; i++)
            corr_ff[i] <= CorrW'(signed'({gyr_ff[i], 8'd0})) - bias_ff[i];
         gsq_ff <= '0;
         asq_ff <= '0;
         sq_idx_ff <= '0;
      end else if (cmd.sq_step) begin
         gsq_ff <= gsq_ff + GsqW'(unsigned'(sq_g));
         asq_ff <= asq_ff + AsqW'(unsigned'(sq_a * sq_a));
         sq_idx_ff <= sq_idx_ff + 1'b1;
         grem_ff <= gsq_ff + GsqW'(unsigned'(sq_g));
         arem_ff <= asq_ff + AsqW'(unsigned'(sq_a * sq_a));
         groot_ff <= '0;
         aroot_ff <= '0;
         gbit_ff <= GsqW'(1) << (GsqW - 2);
         abit_ff <= AsqW'(1) << (AsqW - 2);
      end else if (cmd.sqrt_step) begin
         if (grem_ff >= gtry) begin
            grem_ff <= grem_ff - gtry;
            groot_ff <= (groot_ff >> 1) + gbit_ff;
         end else begin
            groot_ff <= groot_ff >> 1;
         end
         gbit_ff <= gbit_ff >> 2;
         // accel root needs fewer steps, hold it once its bit runs out
         if (abit_ff != '0) begin
            if (arem_ff >= atry) begin
               arem_ff <= arem_ff - atry;
               aroot_ff <= (aroot_ff >> 1) + abit_ff;
            end else begin
               aroot_ff <= aroot_ff >> 1;
            end
            abit_ff <= abit_ff >> 2;
         end
      end
   end

   assign gyro_corr_x = corr_ff[0];
   assign gyro_corr_y = corr_ff[1];
   assign gyro_corr_z = corr_ff[2];
   assign gyro_mag = groot_ff[24:0];
   assign accel_mag = aroot_ff[15:0];
   assign bias_x = bias_ff[0][23:0];
   assign bias_y = bias_ff[1][23:0];
   assign bias_z = bias_ff[2][23:0];
   assign unused = ^{groot_ff[GsqW-1:25], aroot_ff[AsqW-1:16],
                     bias_ff[0][24], bias_ff[1][24], bias_ff[2][24]};
endmodule

### rtl/igbc_control.sv
module igbc_control (
   input  logic clock,
   input  logic reset,
   input  logic req_valid,
   output logic req_stall,
   output logic rsp_valid,
   input  logic rsp_stall,
   input  igbc_pkg::stat_type stat,
   output igbc_pkg::cmd_type cmd,
   output logic [2:0] status,
   output logic converted
);
   import igbc_pkg::*;

   localparam logic [2:0] S_IDLE = 3'd0;
   localparam logic [2:0] S_DECODE = 3'd1;
   localparam logic [2:0] S_DIV = 3'd2;
   localparam logic [2:0] S_SQ = 3'd3;
   localparam logic [2:0] S_SQRT = 3'd4;
   localparam logic [2:0] S_OUT = 3'd5;

   logic [2:0] state_ff, state_in;
   logic [5:0] cnt_ff, cnt_in;
   logic [2:0] status_ff, status_in;
   logic conv_ff, conv_in;

   assign req_stall = state_ff != S_IDLE;
   assign rsp_valid = state_ff == S_OUT;
   assign status = status_ff;
   assign converted = conv_ff;

   always_comb begin
      state_in = state_ff;
      cnt_in = cnt_ff;
      status_in = status_ff;
      conv_in = conv_ff;
      cmd = '0;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = S_DECODE;
            end
         end
         S_DECODE: begin
            conv_in = 1'b0;
            cnt_in = '0;
            unique case (stat.command)
               CMD_ACCUM: begin
                  state_in = S_OUT;
                  if (stat.count_full) status_in = ST_DROPPED;
                  else begin
                     cmd.accumulate = 1'b1;
                     status_in = ST_ACCUMULATED;
                  end
               end
               CMD_FINISH: begin
                  if (stat.count_zero) begin
                     status_in = ST_NO_SAMPLES;
                     state_in = S_OUT;
                  end else begin
                     cmd.div_start = 1'b1;
                     status_in = ST_BIAS_UPDATED;
                     state_in = S_DIV;
                  end
               end
               CMD_CONVERT: begin
                  cmd.sq_start = 1'b1;
                  status_in = ST_CONVERTED;
                  conv_in = 1'b1;
                  state_in = S_SQ;
               end
               default: state_in = S_IDLE;
            endcase
         end
         S_DIV: begin
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == 6'(DivW)) begin
               cmd.div_store = 1'b1;
               cmd.finish_clear = 1'b1;
               state_in = S_OUT;
            end else cmd.div_step = 1'b1;
         end
         S_SQ: begin
            cmd.sq_step = 1'b1;
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == 6'd2) begin
               cnt_in = '0;
               state_in = S_SQRT;
            end
         end
         S_SQRT: begin
            cmd.sqrt_step = 1'b1;
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == 6'(GsqW / 2 - 1)) state_in = S_OUT;
         end
         S_OUT: if (!rsp_stall) state_in = S_IDLE;
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         cnt_ff <= '0;
         status_ff <= '0;
         conv_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         cnt_ff <= cnt_in;
         status_ff <= status_in;
         conv_ff <= conv_in;
      end
   end
endmodule

### rtl/imu_gyro_bias_calibrate_and_magnitude_unit.sv
// accumulate and no-sample finish answer straight from decode, finish runs the divider, convert the squares and root
// the finish time is set by the 37-step restoring divider, convert by the 26-step square root
// the next request is taken only after the result transfer
// synchronous active-high reset clears the sums, the sample count, the bias and the controller
module imu_gyro_bias_calibrate_and_magnitude_unit (
   input  logic clock,
   input  logic reset,
   input  logic req_valid,
   output logic req_stall,
   input  logic [1:0] req_command,
   input  logic signed [15:0] req_accel_raw_x,
   input  logic signed [15:0] req_accel_raw_y,
   input  logic signed [15:0] req_accel_raw_z,
   input  logic signed [15:0] req_gyro_raw_x,
   input  logic signed [15:0] req_gyro_raw_y,
   input  logic signed [15:0] req_gyro_raw_z,
   output logic rsp_valid,
   input  logic rsp_stall,
   output logic [2:0] rsp_status,
   output logic signed [24:0] rsp_gyro_corrected_x,
   output logic signed [24:0] rsp_gyro_corrected_y,
   output logic signed [24:0] rsp_gyro_corrected_z,
   output logic [24:0] rsp_gyro_magnitude,
   output logic [15:0] rsp_accel_magnitude,
   output logic signed [23:0] rsp_bias_x,
   output logic signed [23:0] rsp_bias_y,
   output logic signed [23:0] rsp_bias_z
);
   import igbc_pkg::*;

   cmd_type cmd;
   stat_type stat;
   logic conv;
   logic signed [24:0] cx, cy, cz;
   logic [24:0] gm;
   logic [15:0] am;

   igbc_control u_ctrl (
      .clock, .reset, .req_valid, .req_stall, .rsp_valid, .rsp_stall,
      .stat, .cmd, .status(rsp_status), .converted(conv)
   );

   igbc_datapath u_dp (
      .clock, .reset, .cmd, .stat, .req_command,
      .req_accel_raw_x, .req_accel_raw_y, .req_accel_raw_z,
      .req_gyro_raw_x, .req_gyro_raw_y, .req_gyro_raw_z,
      .gyro_corr_x(cx), .gyro_corr_y(cy), .gyro_corr_z(cz),
      .gyro_mag(gm), .accel_mag(am),
      .bias_x(rsp_bias_x), .bias_y(rsp_bias_y), .bias_z(rsp_bias_z)
   );

   assign rsp_gyro_corrected_x = conv ? cx : '0;
   assign rsp_gyro_corrected_y = conv ? cy : '0;
   assign rsp_gyro_corrected_z = conv ? cz : '0;
   assign rsp_gyro_magnitude = conv ? gm : '0;
   assign rsp_accel_magnitude = conv ? am : '0;
endmodule

### sim/imu_gyro_bias_calibrate_and_magnitude_unit_tb.sv
module imu_gyro_bias_calibrate_and_magnitude_unit_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import igbc_pkg::*;

   localparam logic [1:0] CMD_UNUSED = 2'd3;
   localparam int IdleLimit = 20000;
   localparam int HoldCycles = 400;
   localparam int RandomItems = 1300;

   typedef struct {
      logic [2:0] status;
      logic [24:0] corr_x, corr_y, corr_z;
      logic [24:0] gyro_mag;
      logic [15:0] accel_mag;
      logic [23:0] bias_x, bias_y, bias_z;
   } imu_result_type;

   class bias_scoreboard;
      longint gyro_sum[3];
      longint bias_q8[3];
      int sample_count;
      imu_result_type pending_results[$];
      int errors;
      int results_seen;
      int drops_seen;

      function new();
         for (int i = 0; i < 3; i++) begin
            gyro_sum[i] = 0;
            bias_q8[i] = 0;
         end
         sample_count = 0;
         errors = 0;
         results_seen = 0;
         drops_seen = 0;
      endfunction

      function longint unsigned floor_sqrt(longint unsigned n);
         longint unsigned root;
         longint unsigned bitv;
         root = 0;
         bitv = 64'd1 << 62;
         while (bitv > n) bitv = bitv >> 2;
         while (bitv != 0) begin
            if (n >= root + bitv) begin
               n = n - (root + bitv);
               root = (root >> 1) + bitv;
            end else begin
               root = root >> 1;
            end
            bitv = bitv >> 2;
         end
         return root;
      endfunction

      function void note_request(logic [1:0] cmd, logic signed [15:0] acc[3],
                                 logic signed [15:0] gyr[3]);
         imu_result_type r;
         longint c;
         longint a;
         longint unsigned gsq;
         longint unsigned asq;
         logic [24:0] corr[3];
         if (cmd == CMD_UNUSED) return;
         gsq = 0;
         asq = 0;
         r.status = ST_CONVERTED;
         for (int i = 0; i < 3; i++) corr[i] = '0;
         r.gyro_mag = '0;
         r.accel_mag = '0;
         if (cmd == CMD_ACCUM) begin
            if (sample_count >= MaxSamples) begin
               r.status = ST_DROPPED;
            end else begin
               for (int i = 0; i < 3; i++) gyro_sum[i] += longint'(gyr[i]);
               sample_count++;
               r.status = ST_ACCUMULATED;
            end
         end else if (cmd == CMD_FINISH) begin
            if (sample_count == 0) begin
               r.status = ST_NO_SAMPLES;
            end else begin
               for (int i = 0; i < 3; i++) begin
                  bias_q8[i] = (gyro_sum[i] * 256) / longint'(sample_count);
                  gyro_sum[i] = 0;
               end
               sample_count = 0;
               r.status = ST_BIAS_UPDATED;
            end
         end else begin
            for (int i = 0; i < 3; i++) begin
               c = longint'(gyr[i]) * 256 - bias_q8[i];
               a = longint'(acc[i]);
               corr[i] = c[24:0];
               gsq += longint'(c * c);
               asq += longint'(a * a);
            end
            r.gyro_mag = 25'(floor_sqrt(gsq));
            r.accel_mag = 16'(floor_sqrt(asq));
         end
         r.corr_x = corr[0];
         r.corr_y = corr[1];
         r.corr_z = corr[2];
         r.bias_x = bias_q8[0][23:0];
         r.bias_y = bias_q8[1][23:0];
         r.bias_z = bias_q8[2][23:0];
         pending_results.push_back(r);
      endfunction

      function void check_result(imu_result_type got);
         imu_result_type exp_r;
         results_seen++;
         if (got.status == ST_DROPPED) drops_seen++;
         if (pending_results.size() == 0) begin
            $error("result transfer with nothing pending, status %0d", got.status);
            errors++;
            return;
         end
         exp_r = pending_results.pop_front();
         if (got.status !== exp_r.status) begin
            $error("status: expected %0d, got %0d", exp_r.status, got.status);
            errors++;
         end
         if (got.corr_x !== exp_r.corr_x) begin
            $error("gyro_corrected_x: expected %h, got %h", exp_r.corr_x, got.corr_x);
            errors++;
         end
         if (got.corr_y !== exp_r.corr_y) begin
            $error("gyro_corrected_y: expected %h, got %h", exp_r.corr_y, got.corr_y);
            errors++;
         end
         if (got.corr_z !== exp_r.corr_z) begin
            $error("gyro_corrected_z: expected %h, got %h", exp_r.corr_z, got.corr_z);
            errors++;
         end
         if (got.gyro_mag !== exp_r.gyro_mag) begin
            $error("gyro_magnitude: expected %0d, got %0d", exp_r.gyro_mag, got.gyro_mag);
            errors++;
         end
         if (got.accel_mag !== exp_r.accel_mag) begin
            $error("accel_magnitude: expected %0d, got %0d", exp_r.accel_mag,
                   got.accel_mag);
            errors++;
         end
         if (got.bias_x !== exp_r.bias_x) begin
            $error("bias_x: expected %h, got %h", exp_r.bias_x, got.bias_x);
            errors++;
         end
         if (got.bias_y !== exp_r.bias_y) begin
            $error("bias_y: expected %h, got %h", exp_r.bias_y, got.bias_y);
            errors++;
         end
         if (got.bias_z !== exp_r.bias_z) begin
            $error("bias_z: expected %h, got %h", exp_r.bias_z, got.bias_z);
            errors++;
         end
      endfunction
   endclass

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   logic [1:0] req_command = CMD_ACCUM;
   logic signed [15:0] req_accel_raw_x = '0;
   logic signed [15:0] req_accel_raw_y = '0;
   logic signed [15:0] req_accel_raw_z = '0;
   logic signed [15:0] req_gyro_raw_x = '0;
   logic signed [15:0] req_gyro_raw_y = '0;
   logic signed [15:0] req_gyro_raw_z = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   logic [2:0] rsp_status;
   logic signed [24:0] rsp_gyro_corrected_x;
   logic signed [24:0] rsp_gyro_corrected_y;
   logic signed [24:0] rsp_gyro_corrected_z;
   logic [24:0] rsp_gyro_magnitude;
   logic [15:0] rsp_accel_magnitude;
   logic signed [23:0] rsp_bias_x;
   logic signed [23:0] rsp_bias_y;
   logic signed [23:0] rsp_bias_z;

   bias_scoreboard calib_board = new();
   int idle_pct = 0;
   int stall_pct = 0;
   bit hold_request = 1'b0;
   int hold_left = 0;
   int idle_cycles = 0;
   int items_sent = 0;

   imu_gyro_bias_calibrate_and_magnitude_unit uut (.*);

   initial begin
      forever #1 clock = ~clock;
   end

   // result side stall, with one long hold-off
   initial begin
      forever begin
         @(posedge clock);
         if (hold_request) begin
            hold_request = 1'b0;
            hold_left = HoldCycles;
         end
         if (hold_left > 0) begin
            rsp_stall <= 1'b1;
            hold_left--;
         end else begin
            rsp_stall <= ($urandom_range(99) < stall_pct);
         end
      end
   end

   always @(posedge clock) begin
      logic signed [15:0] acc[3];
      logic signed [15:0] gyr[3];
      imu_result_type got;
      if (!reset) begin
         if (req_valid && !req_stall) begin
            acc[0] = req_accel_raw_x;
            acc[1] = req_accel_raw_y;
            acc[2] = req_accel_raw_z;
            gyr[0] = req_gyro_raw_x;
            gyr[1] = req_gyro_raw_y;
            gyr[2] = req_gyro_raw_z;
            calib_board.note_request(req_command, acc, gyr);
         end
         if (rsp_valid && !rsp_stall) begin
            got.status = rsp_status;
            got.corr_x = rsp_gyro_corrected_x;
            got.corr_y = rsp_gyro_corrected_y;
            got.corr_z = rsp_gyro_corrected_z;
            got.gyro_mag = rsp_gyro_magnitude;
            got.accel_mag = rsp_accel_magnitude;
            got.bias_x = rsp_bias_x;
            got.bias_y = rsp_bias_y;
            got.bias_z = rsp_bias_z;
            calib_board.check_result(got);
         end
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
            idle_cycles = 0;
         end else begin
            idle_cycles++;
            if (idle_cycles >= IdleLimit) begin
               $display("simulation failed");
               $finish;
            end
         end
      end
   end

   task automatic send_sample(logic [1:0] cmd, logic signed [15:0] ax,
                              logic signed [15:0] ay, logic signed [15:0] az,
                              logic signed [15:0] gx, logic signed [15:0] gy,
                              logic signed [15:0] gz);
      if ($urandom_range(99) < idle_pct) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(8, 1)) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_command <= cmd;
      req_accel_raw_x <= ax;
      req_accel_raw_y <= ay;
      req_accel_raw_z <= az;
      req_gyro_raw_x <= gx;
      req_gyro_raw_y <= gy;
      req_gyro_raw_z <= gz;
      do @(posedge clock); while (req_stall);
      items_sent++;
   endtask

   function automatic logic signed [15:0] pick_axis();
      case ($urandom_range(15))
         0: return 16'sh8000;
         1: return 16'sh7fff;
         2: return 16'sh0000;
         3: return -16'sd1;
         default: return 16'($urandom);
      endcase
   endfunction

   task automatic send_random(logic [1:0] cmd);
      send_sample(cmd, pick_axis(), pick_axis(), pick_axis(), pick_axis(),
                  pick_axis(), pick_axis());
   endtask

   initial begin
      int burst;
      int sent_random;
      int phase;
      bit hold_done;
      hold_done = 1'b0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // directed: empty state, extremes, rounding toward zero
      send_sample(CMD_CONVERT, 16'sh8000, 16'sh8000, 16'sh8000,
                  16'sh8000, 16'sh8000, 16'sh8000);
      send_sample(CMD_CONVERT, 16'sh7fff, 16'sh7fff, 16'sh7fff,
                  16'sh7fff, 16'sh7fff, 16'sh7fff);
      send_sample(CMD_FINISH, 0, 0, 0, 0, 0, 0);
      send_sample(CMD_UNUSED, 16'sh7fff, 0, 0, 0, 0, 0);
      send_sample(CMD_ACCUM, 0, 0, 0, -16'sd1, 16'sd1, 16'sh7fff);
      send_sample(CMD_ACCUM, 0, 0, 0, -16'sd1, 16'sd1, 16'sh8000);
      send_sample(CMD_ACCUM, 0, 0, 0, 16'sd0, 16'sd1, 16'sd5);
      send_sample(CMD_FINISH, 0, 0, 0, 0, 0, 0);
      send_sample(CMD_CONVERT, 16'sd3, -16'sd4, 16'sd0, 16'sd0, 16'sd0, 16'sd0);
      send_sample(CMD_CONVERT, 16'sh7fff, 16'sh8000, -16'sd1,
                  16'sh8000, 16'sh7fff, -16'sd1);

      // fill the sample count to its limit with the most negative gyro values
      for (int i = 0; i < MaxSamples; i++) begin
         send_sample(CMD_ACCUM, 0, 0, 0, 16'sh8000, 16'sh8000, 16'sh8000);
      end
      send_sample(CMD_ACCUM, 0, 0, 0, 16'sh7fff, 16'sh7fff, 16'sh7fff);
      send_sample(CMD_FINISH, 0, 0, 0, 0, 0, 0);
      send_sample(CMD_CONVERT, 16'sh8000, 16'sh8000, 16'sh8000,
                  16'sh7fff, 16'sh7fff, 16'sh7fff);
      send_sample(CMD_CONVERT, 16'sh7fff, 16'sh7fff, 16'sh7fff,
                  16'sh8000, 16'sh8000, 16'sh8000);

      // random calibration runs followed by conversions, mixed with bursts of random commands
      sent_random = 0;
      while (sent_random < RandomItems) begin
         phase = (sent_random * 5) / RandomItems;
         case (phase)
            0: begin idle_pct = 0; stall_pct = 0; end
            1: begin idle_pct = 64; stall_pct = 0; end
            2: begin idle_pct = 0; stall_pct = 64; end
            3: begin idle_pct = 21; stall_pct = 21; end
            default: begin idle_pct = 0; stall_pct = 0; end
         endcase
         if (sent_random >= 700 && !hold_done) begin
            hold_done = 1'b1;
            idle_pct = 0;
            hold_request = 1'b1;
         end
         if ($urandom_range(9) < 8) begin
            burst = $urandom_range(20, 1);
            for (int i = 0; i < burst; i++) send_random(CMD_ACCUM);
            send_random(CMD_FINISH);
            burst = $urandom_range(6, 1);
            for (int i = 0; i < burst; i++) send_random(CMD_CONVERT);
            sent_random += 0;
         end else begin
            burst = $urandom_range(5, 1);
            for (int i = 0; i < burst; i++) send_random(2'($urandom_range(3)));
         end
         sent_random = items_sent - MaxSamples - 14;
      end
      req_valid <= 1'b0;

      while (calib_board.pending_results.size() != 0) @(posedge clock);
      repeat (80) @(posedge clock);

      $display("%0d transfers in, %0d results checked, %0d dropped samples",
               items_sent, calib_board.results_seen, calib_board.drops_seen);
      $display("covered accumulate, finish, convert, unused command and full count");
      if (calib_board.pending_results.size() != 0) calib_board.errors++;
      if (calib_board.errors == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end
endmodule
